// ----- sv/lgve_pkg.sv -----
`timescale 1ns / 1ps
// Types, constants and rotation coefficients for the link gravity vector estimator.
package lgve_pkg;

  typedef enum logic [1:0] {
    ROLE_DIFF,
    ROLE_BASE,
    ROLE_GRIP,
    ROLE_MID
  } role_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAT,
    ST_ZCHK,
    ST_NORM,
    ST_SQ,
    ST_ROOT,
    ST_DIVLD,
    ST_DIV,
    ST_EMA,
    ST_OUT
  } state_e;

  localparam logic [7:0] REG_LINK_COUNT = 8'd0;
  localparam logic [7:0] REG_DIFF_MASK  = 8'd1;

  localparam logic [3:0] LINK_COUNT_RST = 4'd5;
  localparam logic [7:0] DIFF_MASK_RST  = 8'd14;

  // 9.80665 in Q.16, and the smoothing weights in Q.16.
  localparam logic [19:0] GRAV_Q16 = 20'd642689;
  localparam logic signed [17:0] KEEP_Q16 = 18'sd64881;
  localparam logic signed [10:0] TAKE_Q16 = 11'sd655;

  localparam int DIV_STEPS = 22;

  // Q2.14 rotation coefficients by role, row and column.
  function automatic logic signed [15:0] coef(role_e role, logic [1:0] row, logic [1:0] col);
    logic [3:0] k;
    logic signed [15:0] r;
    k = {row, col};
    r = 16'sd0;
    case (role)
      ROLE_DIFF: begin
        case (k)
          4'h0: r = -16'sd5430;
          4'h1: r = 16'sd15458;
          4'h6: r = -16'sd16384;
          4'h8: r = -16'sd15458;
          4'h9: r = -16'sd5430;
          default: r = 16'sd0;
        endcase
      end
      ROLE_BASE: begin
        case (k)
          4'h0: r = -16'sd6552;
          4'h1: r = -16'sd15017;
          4'h4: r = 16'sd15017;
          4'h5: r = -16'sd6552;
          4'hA: r = 16'sd16384;
          default: r = 16'sd0;
        endcase
      end
      ROLE_GRIP: begin
        case (k)
          4'h1: r = 16'sd16384;
          4'h4: r = 16'sd16384;
          4'hA: r = -16'sd16384;
          default: r = 16'sd0;
        endcase
      end
      default: begin
        case (k)
          4'h0, 4'h5, 4'hA: r = 16'sd16384;
          default: r = 16'sd0;
        endcase
      end
    endcase
    return r;
  endfunction

  // Round a Q7.16 value half up to Q7.8 and saturate.
  function automatic logic [15:0] to_q8(logic signed [23:0] s);
    logic signed [24:0] t;
    t = {s[23], s} + 25'sd128;
    if (!t[24] && t[23]) begin
      return 16'h7FFF;
    end
    return t[23:8];
  endfunction

endpackage

// ----- sv/link_gravity_vector_estimator.sv -----
`timescale 1ns / 1ps
// Top level: per-link gravity direction estimate with exponential smoothing.
//
// Usage: readings enter on the s_axis channel, one link per transaction
// (tuser carries the link index, tdata the right and left sensor vectors).
// Each reading for a link below link_count gives one result on m_axis:
// the link's smoothed gravity vector in Q7.8 and a flag for a zero reading.
// Readings for links out of range are taken and dropped without a result.
// The cfg channel writes link_count (index 0) and differential_mask
// (index 1); it is always ready. The user must write it only while the
// block is idle; the block itself does not enforce this.
// One item is processed at a time: matrix products, normalizing shifts,
// three squares, a bit-serial square root, three bit-serial divisions
// and smoothing. A zero reading skips straight to the output. The next
// reading is taken once the result is in the output register.
// The square root and divider set the rate.
// A result waits in the output register while the receiver stalls; the next
// reading is still taken and held at its last step until that register frees.
// Reset clears the smoothed state to zero and sets link_count to 5 and
// differential_mask to 14.
module link_gravity_vector_estimator #(
  parameter int MAX_LINKS = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // right_x, right_y, right_z, left_x, left_y, left_z from bit 0 up
  input  logic [95:0]  s_axis_tdata,
  // link_index
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // gravity_x, gravity_y, gravity_z from bit 0 up
  output logic [47:0]  m_axis_tdata,
  // out_link, zero_reading from bit 0 up
  output logic [3:0]   m_axis_tuser,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [7:0]   cfg_index_i,
  input  logic [7:0]   cfg_data_i
);

  lgve_pkg::state_e state_q, state_d;
  lgve_pkg::role_e  role_q, role_d;

  logic [3:0]  link_count_q, link_count_d;
  logic [7:0]  diff_mask_q, diff_mask_d;
  logic [2:0]  idx_q, idx_d;
  logic signed [16:0] v_q [3];
  logic signed [16:0] v_d [3];
  logic signed [34:0] acc_q, acc_d;
  logic [33:0] mag_q [3];
  logic [33:0] mag_d [3];
  logic [2:0]  sgn_q, sgn_d;
  logic [1:0]  row_q, row_d, col_q, col_d;
  logic [1:0]  j_q, j_d;
  logic [61:0] sq_q, sq_d;
  logic [61:0] n_q, n_d;
  logic [61:0] res_q, res_d;
  logic [60:0] bit_q, bit_d;
  logic [31:0] rem_q, rem_d;
  logic [21:0] nlo_q, nlo_d;
  logic [21:0] quo_q, quo_d;
  logic [4:0]  cnt_q, cnt_d;
  logic signed [22:0] g_q [3];
  logic signed [22:0] g_d [3];
  logic        zero_q, zero_d;
  logic signed [23:0] smooth_q [3][MAX_LINKS];
  logic        out_valid_q, out_valid_d;
  logic [47:0] out_data_q, out_data_d;
  logic [3:0]  out_user_q, out_user_d;

  logic        in_fire, in_range, out_free, is_diff;
  logic [33:0] max_mag;
  logic signed [32:0] mat_prod;
  logic signed [34:0] acc_next;
  logic [59:0] sq_prod;
  logic [61:0] trial;
  logic [30:0] root;
  logic [49:0] n_prod;
  logic [50:0] numer;
  logic [31:0] div_t;
  logic        div_ge;
  logic signed [23:0] old_s;
  logic signed [41:0] keep_p;
  logic signed [33:0] take_p;
  logic signed [42:0] ema_sum;

  assign s_axis_tready = (state_q == lgve_pkg::ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign in_range      = ({1'b0, s_axis_tuser} < link_count_q) && (32'(s_axis_tuser) < MAX_LINKS);
  assign is_diff       = diff_mask_q[s_axis_tuser];
  assign out_free      = !out_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  always_comb begin
    max_mag = mag_q[0];
    if (mag_q[1] > max_mag) max_mag = mag_q[1];
    if (mag_q[2] > max_mag) max_mag = mag_q[2];
  end

  assign mat_prod = v_q[col_q] * lgve_pkg::coef(role_q, row_q, col_q);
  assign acc_next = ((col_q == 2'd0) ? 35'sd0 : acc_q) + {{2{mat_prod[32]}}, mat_prod};
  assign sq_prod  = mag_q[j_q][29:0] * mag_q[j_q][29:0];
  assign trial    = res_q + {1'b0, bit_q};
  assign root     = res_q[30:0];
  assign n_prod   = lgve_pkg::GRAV_Q16 * mag_q[j_q][29:0];
  assign numer    = {1'b0, n_prod} + {21'b0, root[30:1]};
  assign div_t    = {rem_q[30:0], nlo_q[21]};
  assign div_ge   = div_t >= {1'b0, root};
  assign old_s    = smooth_q[j_q][idx_q];
  assign keep_p   = old_s * lgve_pkg::KEEP_Q16;
  assign take_p   = g_q[j_q] * lgve_pkg::TAKE_Q16;
  assign ema_sum  = {keep_p[41], keep_p} + {{9{take_p[33]}}, take_p} + 43'sd32768;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      lgve_pkg::ST_IDLE: if (in_fire && in_range) state_d = lgve_pkg::ST_MAT;
      lgve_pkg::ST_MAT: if (row_q == 2'd2 && col_q == 2'd2) state_d = lgve_pkg::ST_ZCHK;
      lgve_pkg::ST_ZCHK: begin
        state_d = (max_mag == '0) ? lgve_pkg::ST_OUT : lgve_pkg::ST_NORM;
      end
      lgve_pkg::ST_NORM: begin
        if (!(|max_mag[33:30]) && max_mag[29]) state_d = lgve_pkg::ST_SQ;
      end
      lgve_pkg::ST_SQ: if (j_q == 2'd2) state_d = lgve_pkg::ST_ROOT;
      lgve_pkg::ST_ROOT: if (bit_q[0]) state_d = lgve_pkg::ST_DIVLD;
      lgve_pkg::ST_DIVLD: state_d = lgve_pkg::ST_DIV;
      lgve_pkg::ST_DIV: begin
        if (cnt_q == 5'(lgve_pkg::DIV_STEPS - 1)) begin
          state_d = (j_q == 2'd2) ? lgve_pkg::ST_EMA : lgve_pkg::ST_DIVLD;
        end
      end
      lgve_pkg::ST_EMA: if (j_q == 2'd2) state_d = lgve_pkg::ST_OUT;
      lgve_pkg::ST_OUT: if (out_free) state_d = lgve_pkg::ST_IDLE;
      default: state_d = lgve_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    link_count_d = link_count_q;
    diff_mask_d  = diff_mask_q;
    role_d = role_q;
    idx_d  = idx_q;
    v_d    = v_q;
    acc_d  = acc_q;
    mag_d  = mag_q;
    sgn_d  = sgn_q;
    row_d  = row_q;
    col_d  = col_q;
    j_d    = j_q;
    sq_d   = sq_q;
    n_d    = n_q;
    res_d  = res_q;
    bit_d  = bit_q;
    rem_d  = rem_q;
    nlo_d  = nlo_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    g_d    = g_q;
    zero_d = zero_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;

    if (cfg_valid_i) begin
      if (cfg_index_i == lgve_pkg::REG_LINK_COUNT) link_count_d = cfg_data_i[3:0];
      else if (cfg_index_i == lgve_pkg::REG_DIFF_MASK) diff_mask_d = cfg_data_i;
    end

    case (state_q)
      lgve_pkg::ST_IDLE: begin
        idx_d = s_axis_tuser;
        row_d = 2'd0;
        col_d = 2'd0;
        zero_d = 1'b0;
        if (is_diff) begin
          role_d = lgve_pkg::ROLE_DIFF;
          v_d[0] = $signed({s_axis_tdata[15], s_axis_tdata[15:0]})
                 - $signed({s_axis_tdata[63], s_axis_tdata[63:48]});
          v_d[1] = $signed({s_axis_tdata[31], s_axis_tdata[31:16]})
                 + $signed({s_axis_tdata[79], s_axis_tdata[79:64]});
          v_d[2] = $signed({s_axis_tdata[47], s_axis_tdata[47:32]})
                 - $signed({s_axis_tdata[95], s_axis_tdata[95:80]});
        end else begin
          if (s_axis_tuser == 3'd0) role_d = lgve_pkg::ROLE_BASE;
          else if ({1'b0, s_axis_tuser} == link_count_q - 4'd1) role_d = lgve_pkg::ROLE_GRIP;
          else role_d = lgve_pkg::ROLE_MID;
          v_d[0] = $signed({s_axis_tdata[15], s_axis_tdata[15:0]});
          v_d[1] = $signed({s_axis_tdata[31], s_axis_tdata[31:16]});
          v_d[2] = $signed({s_axis_tdata[47], s_axis_tdata[47:32]});
        end
      end
      lgve_pkg::ST_MAT: begin
        acc_d = acc_next;
        if (col_q == 2'd2) begin
          sgn_d[row_q] = acc_next[34];
          mag_d[row_q] = acc_next[34] ? 34'(-acc_next) : acc_next[33:0];
          col_d = 2'd0;
          row_d = row_q + 2'd1;
        end else begin
          col_d = col_q + 2'd1;
        end
      end
      lgve_pkg::ST_ZCHK: begin
        zero_d = (max_mag == '0);
        j_d = 2'd0;
        sq_d = '0;
      end
      lgve_pkg::ST_NORM: begin
        // Halving on magnitudes truncates toward zero.
        if (|max_mag[33:30]) begin
          for (int i = 0; i < 3; i++) mag_d[i] = mag_q[i] >> 1;
        end else if (!max_mag[29]) begin
          for (int i = 0; i < 3; i++) mag_d[i] = mag_q[i] << 1;
        end
      end
      lgve_pkg::ST_SQ: begin
        sq_d = sq_q + {2'b0, sq_prod};
        j_d  = j_q + 2'd1;
        if (j_q == 2'd2) begin
          n_d   = sq_q + {2'b0, sq_prod};
          res_d = '0;
          bit_d = 61'd1 << 60;
          j_d   = 2'd0;
        end
      end
      lgve_pkg::ST_ROOT: begin
        if (n_q >= trial) begin
          n_d   = n_q - trial;
          res_d = (res_q >> 1) + {1'b0, bit_q};
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
      end
      lgve_pkg::ST_DIVLD: begin
        rem_d = {3'b0, numer[50:22]};
        nlo_d = numer[21:0];
        cnt_d = '0;
      end
      lgve_pkg::ST_DIV: begin
        rem_d = div_ge ? div_t - {1'b0, root} : div_t;
        nlo_d = nlo_q << 1;
        quo_d = {quo_q[20:0], div_ge};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(lgve_pkg::DIV_STEPS - 1)) begin
          g_d[j_q] = sgn_q[j_q] ? $signed({1'b0, quo_d}) : -$signed({1'b0, quo_d});
          j_d = (j_q == 2'd2) ? 2'd0 : j_q + 2'd1;
        end
      end
      lgve_pkg::ST_EMA: begin
        j_d = j_q + 2'd1;
      end
      lgve_pkg::ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {lgve_pkg::to_q8(smooth_q[2][idx_q]),
                         lgve_pkg::to_q8(smooth_q[1][idx_q]),
                         lgve_pkg::to_q8(smooth_q[0][idx_q])};
          out_user_d  = {zero_q, idx_q};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= lgve_pkg::ST_IDLE;
      link_count_q <= lgve_pkg::LINK_COUNT_RST;
      diff_mask_q  <= lgve_pkg::DIFF_MASK_RST;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < MAX_LINKS; k++) smooth_q[i][k] <= '0;
      end
    end else begin
      state_q      <= state_d;
      link_count_q <= link_count_d;
      diff_mask_q  <= diff_mask_d;
      out_valid_q  <= out_valid_d;
      if (state_q == lgve_pkg::ST_EMA) begin
        smooth_q[j_q][idx_q] <= ema_sum[39:16];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    role_q <= role_d;
    idx_q  <= idx_d;
    v_q    <= v_d;
    acc_q  <= acc_d;
    mag_q  <= mag_d;
    sgn_q  <= sgn_d;
    row_q  <= row_d;
    col_q  <= col_d;
    j_q    <= j_d;
    sq_q   <= sq_d;
    n_q    <= n_d;
    res_q  <= res_d;
    bit_q  <= bit_d;
    rem_q  <= rem_d;
    nlo_q  <= nlo_d;
    quo_q  <= quo_d;
    cnt_q  <= cnt_d;
    g_q    <= g_d;
    zero_q <= zero_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

endmodule
